@@ rtl/chks_pkg.sv @@
// shared constants, command codes and controller/datapath interface types
package chks_pkg;

  localparam int KEY_W      = 21;
  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 13;
  localparam int TABLE_SIZE = 6001;
  localparam int KICK_LIMIT = 128;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int KICK_W = $clog2(KICK_LIMIT + 1);

  // hash word and reciprocal for the constant modulo
  localparam int HASH_W    = 32;
  localparam int MOD_SHIFT = HASH_W + IDX_W;
  localparam int RECIP_W   = HASH_W + 1;
  localparam int PROD_W    = HASH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((65'd1 << MOD_SHIFT) / TABLE_SIZE);

  localparam logic [HASH_W-1:0] MULT_ONE = 32'd2654435761;
  localparam logic [HASH_W-1:0] MULT_TWO = 32'd3344921057;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // carried key source select
  localparam logic [1:0] CARRY_HOLD = 2'd0;
  localparam logic [1:0] CARRY_IN   = 2'd1;
  localparam logic [1:0] CARRY_RD1  = 2'd2;
  localparam logic [1:0] CARRY_RD2  = 2'd3;

  typedef struct packed {
    logic [1:0] carry_sel;
    logic       hash_go;
    logic       rd1;
    logic       rd2;
    logic       wr1;
    logic       wr2;
    logic       clr;
    logic       out_go;
    logic       out_hit;
    logic       out_tab;
    logic       out_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic eq1;
    logic eq2;
    logic zero1;
    logic zero2;
    logic key_zero;
    logic clr_last;
  } dp_sts_t;

endpackage

@@ rtl/chks_hash.sv @@
// two-lane pipelined multiplicative hash with constant modulo reduction
module chks_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [chks_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [chks_pkg::IDX_W-1:0] h1,
  output logic [chks_pkg::IDX_W-1:0] h2
);
  import chks_pkg::*;

  logic [3:0]        vld_r;
  logic [HASH_W-1:0] p_r  [2];
  logic [HASH_W-1:0] p2_r [2];
  logic [HASH_W-1:0] p3_r [2];
  logic [HASH_W-1:0] q_r  [2];
  logic [HASH_W-1:0] m_r  [2];
  logic [IDX_W-1:0]  h_r  [2];

  logic [HASH_W-1:0] p_nxt [2];
  logic [PROD_W-1:0] prod  [2];
  logic [HASH_W-1:0] q_nxt [2];
  logic [HASH_W-1:0] r     [2];
  logic [IDX_W-1:0]  h_nxt [2];

  always_comb begin
    p_nxt[0] = HASH_W'(HASH_W'(key) * MULT_ONE);
    p_nxt[1] = HASH_W'(HASH_W'(key) * MULT_TWO);
    for (int i = 0; i < 2; i++) begin
      prod[i]  = PROD_W'(p_r[i]) * PROD_W'(RECIP);
      // estimate is the true quotient or one below it
      q_nxt[i] = HASH_W'(prod[i] >> MOD_SHIFT);
      r[i]     = p3_r[i] - m_r[i];
      if (r[i] >= HASH_W'(TABLE_SIZE)) begin
        h_nxt[i] = IDX_W'(r[i] - HASH_W'(TABLE_SIZE));
      end else begin
        h_nxt[i] = IDX_W'(r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], go};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      p_r[i]  <= p_nxt[i];
      p2_r[i] <= p_r[i];
      q_r[i]  <= q_nxt[i];
      p3_r[i] <= p2_r[i];
      m_r[i]  <= HASH_W'(q_r[i] * HASH_W'(TABLE_SIZE));
      if (vld_r[2]) begin
        h_r[i] <= h_nxt[i];
      end
    end
  end

  assign done = vld_r[3];
  assign h1   = h_r[0];
  assign h2   = h_r[1];

endmodule

@@ rtl/chks_dp.sv @@
// datapath: carried key, hash unit, both key tables, clear sweep and result word
module chks_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [chks_pkg::KEY_W-1:0]  in_key,
  input  chks_pkg::dp_cmd_t          cmd,
  output chks_pkg::dp_sts_t          sts,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic                       out_which_table,
  output logic [chks_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_insert_ok
);
  import chks_pkg::*;

  logic [KEY_W-1:0] carry_r;
  logic [KEY_W-1:0] carry_nxt;
  logic [KEY_W-1:0] rd1_r;
  logic [KEY_W-1:0] rd2_r;
  logic [IDX_W-1:0] clr_addr_r;
  logic [IDX_W-1:0] h1;
  logic [IDX_W-1:0] h2;
  logic             hash_done;
  logic             clr_last;

  logic [KEY_W-1:0] first_mem  [TABLE_SIZE];
  logic [KEY_W-1:0] second_mem [TABLE_SIZE];

  logic              out_valid_r;
  logic              out_hit_r;
  logic              out_tab_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_ok_r;
  logic [IDX_W-1:0]  slot_idx;
  logic [HASH_W-1:0] slot_ext;

  always_comb begin
    case (cmd.carry_sel)
      CARRY_IN:  carry_nxt = in_key;
      CARRY_RD1: carry_nxt = rd1_r;
      CARRY_RD2: carry_nxt = rd2_r;
      default:   carry_nxt = carry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

  chks_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.hash_go),
    .key   (carry_nxt),
    .done  (hash_done),
    .h1    (h1),
    .h2    (h2)
  );

  assign clr_last = (clr_addr_r == IDX_W'(TABLE_SIZE - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      first_mem[clr_addr_r] <= '0;
    end else if (cmd.wr1) begin
      first_mem[h1] <= carry_r;
    end
    if (cmd.rd1) begin
      rd1_r <= first_mem[h1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      second_mem[clr_addr_r] <= '0;
    end else if (cmd.wr2) begin
      second_mem[h2] <= carry_r;
    end
    if (cmd.rd2) begin
      rd2_r <= second_mem[h2];
    end
  end

  always_comb begin
    sts.hash_done = hash_done;
    sts.eq1       = (rd1_r == carry_r);
    sts.eq2       = (rd2_r == carry_r);
    sts.zero1     = (rd1_r == '0);
    sts.zero2     = (rd2_r == '0);
    sts.key_zero  = (in_key == '0);
    sts.clr_last  = clr_last;
  end

  assign slot_idx = cmd.out_tab ? h2 : h1;
  assign slot_ext = {{(HASH_W - IDX_W){1'b0}}, slot_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_go) begin
      out_hit_r  <= cmd.out_hit;
      out_tab_r  <= cmd.out_hit & cmd.out_tab;
      out_slot_r <= cmd.out_hit ? slot_ext[SLOT_W-1:0] : '0;
      out_ok_r   <= cmd.out_ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_which_table = out_tab_r;
  assign out_slot        = out_slot_r;
  assign out_insert_ok   = out_ok_r;

endmodule

@@ rtl/chks_ctrl.sv @@
// controller state machine: lookup, insert with kicking, clear sweep
module chks_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [chks_pkg::CMD_W-1:0]  in_command,
  input  chks_pkg::dp_sts_t          sts,
  output chks_pkg::dp_cmd_t          cmd,
  output logic                       busy
);
  import chks_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_KH2  = 3'd4;
  localparam logic [2:0] S_KC2  = 3'd5;
  localparam logic [2:0] S_KH1  = 3'd6;
  localparam logic [2:0] S_KC1  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic             lookup_r, lookup_nxt;
  logic [KICK_W-1:0] round_r, round_nxt;
  logic             clr_resp_r, clr_resp_nxt;

  always_comb begin
    state_nxt    = state_r;
    lookup_nxt   = lookup_r;
    round_nxt    = round_r;
    clr_resp_nxt = clr_resp_r;
    cmd          = '0;
    cmd.carry_sel = CARRY_HOLD;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
          if (clr_resp_r) begin
            cmd.out_go = 1'b1;
            cmd.out_ok = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_LOOKUP, CMD_INSERT: begin
              lookup_nxt = (in_command == CMD_LOOKUP);
              if (sts.key_zero) begin
                cmd.out_go = 1'b1;
                cmd.out_ok = (in_command == CMD_INSERT);
              end else begin
                cmd.carry_sel = CARRY_IN;
                cmd.hash_go   = 1'b1;
                state_nxt     = S_HASH;
              end
            end
            CMD_CLEAR: begin
              clr_resp_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            default: begin
              cmd.out_go = 1'b1;
            end
          endcase
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          cmd.rd1   = 1'b1;
          cmd.rd2   = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (lookup_r) begin
          cmd.out_go  = 1'b1;
          cmd.out_hit = sts.eq1 | sts.eq2;
          cmd.out_tab = ~sts.eq1;
          state_nxt   = S_IDLE;
        end else if (sts.eq1 || sts.eq2) begin
          cmd.out_go = 1'b1;
          cmd.out_ok = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.zero1) begin
          cmd.wr1    = 1'b1;
          cmd.out_go = 1'b1;
          cmd.out_ok = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.zero2) begin
          cmd.wr2    = 1'b1;
          cmd.out_go = 1'b1;
          cmd.out_ok = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          // first kick: displace the first-table resident
          cmd.wr1       = 1'b1;
          cmd.carry_sel = CARRY_RD1;
          cmd.hash_go   = 1'b1;
          round_nxt     = '0;
          state_nxt     = S_KH2;
        end
      end
      S_KH2: begin
        if (sts.hash_done) begin
          cmd.rd2   = 1'b1;
          state_nxt = S_KC2;
        end
      end
      S_KC2: begin
        cmd.wr2 = 1'b1;
        if (sts.zero2) begin
          cmd.out_go = 1'b1;
          cmd.out_ok = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.carry_sel = CARRY_RD2;
          cmd.hash_go   = 1'b1;
          state_nxt     = S_KH1;
        end
      end
      S_KH1: begin
        if (sts.hash_done) begin
          cmd.rd1   = 1'b1;
          state_nxt = S_KC1;
        end
      end
      S_KC1: begin
        if (sts.zero1) begin
          cmd.wr1    = 1'b1;
          cmd.out_go = 1'b1;
          cmd.out_ok = 1'b1;
          state_nxt  = S_IDLE;
        end else if (round_r == KICK_W'(KICK_LIMIT - 1)) begin
          cmd.out_go = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          round_nxt     = round_r + 1'b1;
          cmd.wr1       = 1'b1;
          cmd.carry_sel = CARRY_RD1;
          cmd.hash_go   = 1'b1;
          state_nxt     = S_KH2;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      lookup_r   <= 1'b0;
      round_r    <= '0;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lookup_r   <= lookup_nxt;
      round_r    <= round_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/cuckoo_hash_key_set.sv @@
// top level: two-table cuckoo hash set of codepoint keys
// lookup or insert with no kick: hash pass, table reads, check, registered strobe; the next word
//   is taken back in idle; each table a kick visits adds a hash pass plus a read
// zero key and unused command: strobe in the next cycle, busy stays low
// clear: one slot per cycle over all TABLE_SIZE slots, then the strobe
// reset runs the same clearing pass (busy high), no word; no stall
module cuckoo_hash_key_set (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [chks_pkg::CMD_W-1:0]  in_command,
  input  logic [chks_pkg::KEY_W-1:0]  in_key,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic                       out_which_table,
  output logic [chks_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_insert_ok
);
  import chks_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // controller: sequences hashing, table reads, writes, kicks and the clear sweep
  chks_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (dp_sts),
    .cmd        (dp_cmd),
    .busy       (busy)
  );

  // datapath: carried key, hash pipeline, the two tables and the result word register
  chks_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key          (in_key),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_which_table (out_which_table),
    .out_slot        (out_slot),
    .out_insert_ok   (out_insert_ok)
  );

endmodule

@@ rtl/chks_checker.sv @@
// port-level checker for the cuckoo hash key set, bound to the top level
module chks_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [chks_pkg::CMD_W-1:0]  in_command,
  input logic [chks_pkg::KEY_W-1:0]  in_key,
  input logic                       out_valid,
  input logic                       out_hit,
  input logic                       out_which_table,
  input logic [chks_pkg::SLOT_W-1:0] out_slot,
  input logic                       out_insert_ok
);
  import chks_pkg::*;

  // a result word never reports both a hit and an insert status
  a_hit_ok_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_insert_ok))
    else $error("hit and insert_ok both set");

  // a miss carries no table or slot
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_slot == '0 && !out_which_table))
    else $error("miss with nonzero table or slot");

  // a clear keeps the block busy
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_CLEAR) |=> busy)
    else $error("clear accepted but not busy");

  // a result word follows an accepted word or work in progress
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a command");

  // a nonzero lookup or insert makes the block busy, with no result word yet
  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_key != '0 &&
     (in_command == CMD_LOOKUP || in_command == CMD_INSERT)) |=> (busy && !out_valid))
    else $error("nonzero key finished too early");

endmodule

bind cuckoo_hash_key_set chks_checker u_chks_checker (.*);
